### hw/rtl/averaged_power_meter_assert.svh
// Assertion macros for the averaged power meter.
// Expect clk and rst to be in scope where a macro is used.
`ifndef AVERAGED_POWER_METER_ASSERT_SVH
`define AVERAGED_POWER_METER_ASSERT_SVH

// Same-cycle implication, off while in reset
`define APM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apm check failed (same cycle)");

// Next-cycle implication, off while in reset
`define APM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apm check failed (next cycle)");

`endif

### hw/rtl/apm_pkg.sv
// Shared constants for the averaged power meter: window, widths, divisor,
// register indexes and pass codes. No dependencies.
package apm_pkg;

  localparam int WINDOW         = 10;
  localparam int ADC_FULL_SCALE = 4096;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam int OPND_W    = 16;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int MUL_CNT_W = $clog2(OPND_W);
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam int DEN    = WINDOW * ADC_FULL_SCALE;
  localparam int DVSR_W = ($clog2(DEN + 1) > OPND_W) ? $clog2(DEN + 1) : OPND_W;
  localparam int MILLI  = 1000;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VFS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ILOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IHIGH = 2'd2;

  localparam logic [15:0] VFS_RESET   = 16'd25000;
  localparam logic [15:0] ILOW_RESET  = 16'hEC78;  // -5000
  localparam logic [14:0] IHIGH_RESET = 15'd5000;

  // Multiply-divide passes of one item
  localparam logic [1:0] STEP_VOLT  = 2'd0;
  localparam logic [1:0] STEP_AMP   = 2'd1;
  localparam logic [1:0] STEP_POWER = 2'd2;
  localparam logic [1:0] STEP_RES   = 2'd3;

endpackage

### hw/rtl/apm_ring.sv
// Sample rings and running window sums for both channels.
// Depends on apm_pkg.
module apm_ring import apm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [SAMPLE_W-1:0] volt_in,
  input  logic [SAMPLE_W-1:0] amp_in,
  output logic [SUM_W-1:0]    volt_sum,
  output logic [SUM_W-1:0]    amp_sum
);

  logic [SAMPLE_W-1:0] volt_ring [WINDOW];
  logic [SAMPLE_W-1:0] amp_ring  [WINDOW];
  logic [SLOT_W-1:0]   slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        volt_ring[i] <= '0;
        amp_ring[i]  <= '0;
      end
      slot     <= '0;
      volt_sum <= '0;
      amp_sum  <= '0;
    end else if (push) begin
      // drop the oldest sample, add the newest
      volt_sum <= volt_sum - SUM_W'(volt_ring[slot]) + SUM_W'(volt_in);
      amp_sum  <= amp_sum - SUM_W'(amp_ring[slot]) + SUM_W'(amp_in);
      volt_ring[slot] <= volt_in;
      amp_ring[slot]  <= amp_in;
      slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
    end
  end

endmodule

### hw/rtl/apm_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on apm_pkg.
module apm_mul import apm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OPND_W-1:0] a,
  input  logic [OPND_W-1:0] b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [OPND_W-1:0]    mcand;
  logic [PROD_W-1:0]    p;
  logic [OPND_W:0]      part;

  // upper half plus multiplicand when the low bit is set
  assign part = {1'b0, p[PROD_W-1:OPND_W]} + (p[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= MUL_CNT_W'(OPND_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      p     <= {OPND_W'(0), b};
    end else if (busy) begin
      p <= {part, p[OPND_W-1:1]};
    end
  end

  assign done = busy && (cnt == '0);
  assign prod = p;

endmodule

### hw/rtl/apm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on apm_pkg.
module apm_div import apm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic              done,
  output logic [PROD_W-1:0] quo,
  output logic [DVSR_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVSR_W-1:0]    d;
  logic [PROD_W-1:0]    q;
  logic [DVSR_W-1:0]    r;
  logic [DVSR_W:0]      shifted;
  logic [DVSR_W+1:0]    diff;
  logic                 borrow;

  assign shifted = {r, q[PROD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d};
  assign borrow  = diff[DVSR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(PROD_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      // keep the trial difference only when it does not borrow
      r <= borrow ? shifted[DVSR_W-1:0] : diff[DVSR_W-1:0];
      q <= {q[PROD_W-2:0], ~borrow};
    end
  end

  assign done = busy && (cnt == '0);
  assign quo  = q;
  assign rem  = r;

endmodule

### hw/rtl/averaged_power_meter.sv
// Averaged power meter top level: config registers, pass sequencer, result register.
// Depends on apm_pkg, apm_ring, apm_mul, apm_div and averaged_power_meter_assert.svh.
//
//  channel | handshake          | beat carries
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_ready  | volt_sample, amp_sample
//  out     | out_valid/out_ready| window sums, volt_mv, amp_ma, power_mw, resistance
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// An item runs from its in beat to its result as four passes of the shared serial
// multiplier and serial divider, each pass stepping MSTART, MWAIT, DSTART, DWAIT
// and STORE, then LOAD. The next in beat is taken only back in IDLE, after the
// load, so one item is in work at a time.
// in_ready is high only while the sequencer is idle; the result register holds a beat
// while the next item is computed, and the load waits for it to be taken.
// Synchronous reset clears the rings, sums, state and out_valid; config gets defaults.
`include "averaged_power_meter_assert.svh"

module averaged_power_meter import apm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  volt_sample,
  input  logic [SAMPLE_W-1:0]  amp_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SUM_W-1:0]     volt_window_sum,
  output logic [SUM_W-1:0]     amp_window_sum,
  output logic [15:0]          volt_mv,
  output logic signed [15:0]   amp_ma,
  output logic signed [22:0]   power_mw,
  output logic [25:0]          resistance_mohm,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MSTART = 3'd1;
  localparam logic [2:0] ST_MWAIT  = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DWAIT  = 3'd4;
  localparam logic [2:0] ST_STORE  = 3'd5;
  localparam logic [2:0] ST_LOAD   = 3'd6;

  localparam logic signed [34:0] AMP_MAX = 35'sd32767;
  localparam logic signed [34:0] AMP_MIN = -35'sd32768;

  logic [2:0] state, state_next;
  logic [1:0] step;

  logic [15:0]        vfs_mv;
  logic signed [15:0] ilow_ma;
  logic [14:0]        ihigh_ma;

  logic               in_accept;
  logic               out_load;
  logic [SUM_W-1:0]   volt_sum, amp_sum;

  logic [15:0]        vmv;
  logic signed [15:0] ama;
  logic [22:0]        pmw;
  logic [25:0]        rmo;

  logic [17:0]        span, span_abs;
  logic               span_neg;
  logic [15:0]        ama_mag;
  logic               ama_neg, ama_pos;

  logic               mul_start, mul_done;
  logic [OPND_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic               div_start, div_done;
  logic [DVSR_W-1:0]  divisor;
  logic [PROD_W-1:0]  quo;
  logic [DVSR_W-1:0]  rem;

  logic [33:0]        q_ext, qf;
  logic signed [34:0] amp_full;
  logic [15:0]        vmv_next;
  logic signed [15:0] ama_next;
  logic [22:0]        pmw_next;

  // ---------------- configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vfs_mv   <= VFS_RESET;
      ilow_ma  <= ILOW_RESET;
      ihigh_ma <= IHIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VFS:   vfs_mv   <= cfg_data;
        REG_ILOW:  ilow_ma  <= cfg_data;
        REG_IHIGH: ihigh_ma <= cfg_data[14:0];
        default:   ;
      endcase
    end
  end

  // ---------------- datapath units
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  apm_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept),
    .volt_in  (volt_sample),
    .amp_in   (amp_sample),
    .volt_sum (volt_sum),
    .amp_sum  (amp_sum)
  );

  apm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  apm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (divisor),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  assign mul_start = (state == ST_MSTART);
  assign div_start = (state == ST_DSTART);

  // current span may be negative; multiply magnitudes and fix the sign after
  assign span     = {3'b000, ihigh_ma} - {{2{ilow_ma[15]}}, ilow_ma};
  assign span_neg = span[17];
  assign span_abs = span_neg ? (18'd0 - span) : span;

  assign ama_neg = ama[15];
  assign ama_pos = !ama[15] && (ama != 16'sd0);
  assign ama_mag = ama_neg ? (16'd0 - ama) : ama;

  always_comb begin
    unique case (step)
      STEP_VOLT: begin
        mul_a   = volt_sum;
        mul_b   = vfs_mv;
        divisor = DVSR_W'(DEN);
      end
      STEP_AMP: begin
        mul_a   = amp_sum;
        mul_b   = span_abs[15:0];
        divisor = DVSR_W'(DEN);
      end
      STEP_POWER: begin
        mul_a   = vmv;
        mul_b   = ama_mag;
        divisor = DVSR_W'(MILLI);
      end
      default: begin
        mul_a   = vmv;
        mul_b   = OPND_W'(MILLI);
        divisor = DVSR_W'(ama_mag);
      end
    endcase
  end

  // ---------------- per-pass result shaping
  assign vmv_next = (|quo[PROD_W-1:16]) ? 16'hFFFF : quo[15:0];

  // floor toward minus infinity for a negative span, then offset and clamp
  assign q_ext    = {2'b00, quo};
  assign qf       = span_neg ? (34'd0 - q_ext - {33'd0, |rem}) : q_ext;
  assign amp_full = $signed({qf[33], qf}) + $signed({{19{ilow_ma[15]}}, ilow_ma});

  always_comb begin
    priority if (amp_full > AMP_MAX) begin
      ama_next = 16'sh7FFF;
    end else if (amp_full < AMP_MIN) begin
      ama_next = 16'sh8000;
    end else begin
      ama_next = amp_full[15:0];
    end
  end

  assign pmw_next = ama_neg ? (23'd0 - quo[22:0]) : quo[22:0];

  always_ff @(posedge clk) begin
    if (state == ST_STORE) begin
      unique case (step)
        STEP_VOLT:  vmv <= vmv_next;
        STEP_AMP:   ama <= ama_next;
        STEP_POWER: pmw <= pmw_next;
        default:    rmo <= ama_pos ? quo[25:0] : 26'd0;
      endcase
    end
  end

  // ---------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_accept) state_next = ST_MSTART;
      ST_MSTART: state_next = ST_MWAIT;
      ST_MWAIT:  if (mul_done) state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_next = ST_STORE;
      ST_STORE:  state_next = (step == STEP_RES) ? ST_LOAD : ST_MSTART;
      ST_LOAD:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_VOLT;
    end else begin
      state <= state_next;
      if (in_accept) begin
        step <= STEP_VOLT;
      end else if (state == ST_STORE) begin
        step <= step + 1'b1;
      end
    end
  end

  // ---------------- result register
  assign out_load = (state == ST_LOAD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      volt_window_sum <= volt_sum;
      amp_window_sum  <= amp_sum;
      volt_mv         <= vmv;
      amp_ma          <= ama;
      power_mw        <= pmw;
      resistance_mohm <= rmo;
    end
  end

  // ---------------- checks
  `APM_ASSERT_NXT(a_accept_starts, in_accept, state == ST_MSTART && step == STEP_VOLT)
  `APM_ASSERT_IMP(a_mul_done_wait, mul_done, state == ST_MWAIT)
  `APM_ASSERT_IMP(a_div_done_wait, div_done, state == ST_DWAIT)
  `APM_ASSERT_NXT(a_load_shows, out_load, out_valid && state == ST_IDLE)
  `APM_ASSERT_IMP(a_res_zero, out_valid && (amp_ma[15] || amp_ma == 16'sd0),
                  resistance_mohm == 26'd0)

endmodule
